### design/rcs_pkg.sv
package rcs_pkg;

  localparam int unsigned NumLetters = 26;

  typedef logic [4:0] letter_t;
  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ROTOR_I   = 2'd0,
    ROTOR_II  = 2'd1,
    ROTOR_III = 2'd2
  } rotor_e;

  typedef enum logic [2:0] {
    REG_START_POS_FIRST    = 3'd0,
    REG_START_POS_SECOND   = 3'd1,
    REG_START_POS_THIRD    = 3'd2,
    REG_FAST_PHASE_START   = 3'd3,
    REG_MIDDLE_PHASE_START = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_ENCIPHER = 1'b0,
    OP_RELOAD   = 1'b1
  } op_e;

  localparam byte_t CharSpace = 8'h20;
  localparam byte_t CharBad   = 8'h2F;
  localparam byte_t CharUpA   = 8'h41;
  localparam byte_t CharUpZ   = 8'h5A;
  localparam byte_t CharLoA   = 8'h61;
  localparam byte_t CharLoZ   = 8'h7A;
  localparam byte_t CaseBit   = 8'h20;

  localparam letter_t LastLetter = 5'(NumLetters - 1);

  // Rotor wirings (position -> letter) and their inverses (letter -> position)
  localparam letter_t RotFwdI [NumLetters] = '{
    5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
  localparam letter_t RotFwdII [NumLetters] = '{
    5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
    5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
  localparam letter_t RotFwdIII [NumLetters] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
  localparam letter_t RotInvI [NumLetters] = '{
    5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
    5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
  localparam letter_t RotInvII [NumLetters] = '{
    5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
  localparam letter_t RotInvIII [NumLetters] = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};
  localparam letter_t ReflB [NumLetters] = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19};
  // Plugboard is an involution
  localparam letter_t Plug [NumLetters] = '{
    5'd14, 5'd6, 5'd21, 5'd3, 5'd25, 5'd16, 5'd1, 5'd15, 5'd11, 5'd23, 5'd10, 5'd8, 5'd13,
    5'd12, 5'd0, 5'd7, 5'd5, 5'd17, 5'd19, 5'd18, 5'd20, 5'd2, 5'd22, 5'd9, 5'd24, 5'd4};

  typedef struct packed {
    letter_t first;
    letter_t second;
    letter_t third;
  } rcs_offsets_t;

  function automatic letter_t mod26(input letter_t v);
    return (v > LastLetter) ? 5'(v - 5'(NumLetters)) : v;
  endfunction

  function automatic letter_t add26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'(NumLetters)) ? s[4:0] - 5'(NumLetters) : s[4:0];
  endfunction

  function automatic letter_t sub26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + 6'(NumLetters) - {1'b0, b};
    return (s >= 6'(NumLetters)) ? s[4:0] - 5'(NumLetters) : s[4:0];
  endfunction

  function automatic letter_t tbl_rd(input letter_t tbl [NumLetters], input letter_t i);
    return (i > LastLetter) ? '0 : tbl[i];
  endfunction

  function automatic letter_t rot_fwd(input rotor_e k, input letter_t i);
    letter_t r;
    unique case (k)
      ROTOR_I:   r = tbl_rd(RotFwdI, i);
      ROTOR_II:  r = tbl_rd(RotFwdII, i);
      ROTOR_III: r = tbl_rd(RotFwdIII, i);
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic letter_t rot_inv(input rotor_e k, input letter_t x);
    letter_t r;
    unique case (k)
      ROTOR_I:   r = tbl_rd(RotInvI, x);
      ROTOR_II:  r = tbl_rd(RotInvII, x);
      ROTOR_III: r = tbl_rd(RotInvIII, x);
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Position of x in wiring a (rotated by oa) picks the letter there in wiring b (rotated by ob)
  function automatic letter_t hop(input rotor_e a, input letter_t oa,
                                  input rotor_e b, input letter_t ob, input letter_t x);
    letter_t p;
    p = add26(rot_inv(a, x), oa);
    return rot_fwd(b, sub26(p, ob));
  endfunction

endpackage

### design/rcs_if.sv
interface rcs_in_if;
  import rcs_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  byte_t char_in;

  modport source (output valid, output op, output char_in, input ready);
  modport sink   (input valid, input op, input char_in, output ready);
endinterface

interface rcs_out_if;
  import rcs_pkg::*;
  logic  valid;
  logic  ready;
  byte_t char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

### design/rcs_core.sv
module rcs_core
  import rcs_pkg::*;
(
  input  byte_t        char_i,
  input  rcs_offsets_t offs_i,
  output byte_t        char_o
);

  byte_t   lower;
  logic    is_letter;
  letter_t x_plug, x_h1, x_h2, x_refl, x_h3, x_h4, x_out;

  always_comb begin
    lower = char_i;
    if (char_i >= CharUpA && char_i <= CharUpZ) begin
      lower = char_i | CaseBit;
    end
    is_letter = (lower >= CharLoA) && (lower <= CharLoZ);
  end

  always_comb begin
    x_plug = tbl_rd(Plug, 5'(lower - CharLoA));
    x_h1   = hop(ROTOR_I, offs_i.first, ROTOR_II, offs_i.second, x_plug);
    x_h2   = hop(ROTOR_II, offs_i.second, ROTOR_III, offs_i.third, x_h1);
    x_refl = tbl_rd(ReflB, x_h2);
    x_h3   = hop(ROTOR_III, offs_i.third, ROTOR_II, offs_i.second, x_refl);
    x_h4   = hop(ROTOR_II, offs_i.second, ROTOR_I, offs_i.first, x_h3);
    x_out  = tbl_rd(Plug, x_h4);
  end

  always_comb begin
    priority if (char_i == CharSpace) begin
      char_o = CharSpace;
    end else if (is_letter) begin
      char_o = CharLoA + {3'b000, x_out};
    end else begin
      char_o = CharBad;
    end
  end

endmodule

### design/rotor_cipher_stream.sv
// Channel  Dir  Payload                       Handshake
// in_i     in   op (1), char_in (8)           valid/ready
// out_o    out  char_out (8)                  valid/ready
// cfg      in   cfg_idx_i (3), cfg_data_i (5) cfg_we_i, no stall
//
// One request per cycle sustained while out_o is not stalled; a taken request is held in
// stage one, then in the output register, which drives out_o.valid.
// Stage one registers the request; the rotor chain runs combinationally into the
// output register, and rotor state updates when a request leaves stage one.
// A stalled output holds both stages; stage one refills as the output drains.
// Reset: offsets 0, both phases 1, registers at the same values, pipeline empty.
module rotor_cipher_stream
  import rcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  letter_t     cfg_data_i,
  rcs_in_if.sink      in_i,
  rcs_out_if.source   out_o
);

  letter_t cfg_pos1_q, cfg_pos2_q, cfg_pos3_q, cfg_fast_q, cfg_mid_q;

  logic  s1_valid_q;
  logic  s1_op_q;
  byte_t s1_char_q;

  logic  out_valid_q;
  byte_t out_char_q;

  rcs_offsets_t offs_q, offs_d;
  letter_t      fast_q, fast_d, mid_q, mid_d;

  logic  advance;
  logic  steps;
  byte_t core_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pos1_q <= '0;
      cfg_pos2_q <= '0;
      cfg_pos3_q <= '0;
      cfg_fast_q <= 5'd1;
      cfg_mid_q  <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_POS_FIRST:    cfg_pos1_q <= cfg_data_i;
        REG_START_POS_SECOND:   cfg_pos2_q <= cfg_data_i;
        REG_START_POS_THIRD:    cfg_pos3_q <= cfg_data_i;
        REG_FAST_PHASE_START:   cfg_fast_q <= cfg_data_i;
        REG_MIDDLE_PHASE_START: cfg_mid_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.char_out = out_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.op;
      s1_char_q <= in_i.char_in;
    end
  end

  rcs_core u_core (
    .char_i (s1_char_q),
    .offs_i (offs_q),
    .char_o (core_char)
  );

  assign steps = (s1_op_q == OP_ENCIPHER) && (s1_char_q != CharSpace);

  always_comb begin
    offs_d = offs_q;
    fast_d = fast_q;
    mid_d  = mid_q;
    if (s1_op_q == OP_RELOAD) begin
      offs_d.first  = mod26(cfg_pos1_q);
      offs_d.second = mod26(cfg_pos2_q);
      offs_d.third  = mod26(cfg_pos3_q);
      fast_d        = mod26(cfg_fast_q);
      mid_d         = mod26(cfg_mid_q);
    end else if (steps) begin
      offs_d.first = add26(offs_q.first, 5'd1);
      if (fast_q == '0) begin
        offs_d.second = add26(offs_q.second, 5'd1);
      end
      if (fast_q == '0 && mid_q == '0) begin
        offs_d.third = add26(offs_q.third, 5'd1);
      end
      fast_d = add26(fast_q, 5'd1);
      // middle phase moves when the fast phase wraps
      if (fast_d == '0) begin
        mid_d = add26(mid_q, 5'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
      fast_q <= 5'd1;
      mid_q  <= 5'd1;
    end else if (advance) begin
      offs_q <= offs_d;
      fast_q <= fast_d;
      mid_q  <= mid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_char_q <= (s1_op_q == OP_RELOAD) ? 8'h00 : core_char;
    end
  end

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offs_q.first <= LastLetter && offs_q.second <= LastLetter &&
    offs_q.third <= LastLetter && fast_q <= LastLetter && mid_q <= LastLetter)
    else $error("rotor state out of range");

  a_first_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && steps |=> offs_q.first == add26($past(offs_q.first), 5'd1))
    else $error("first rotor did not step");

  a_space_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_op_q == OP_ENCIPHER && s1_char_q == CharSpace
    |=> $stable(offs_q) && $stable(fast_q) && $stable(mid_q))
    else $error("space changed rotor state");

  a_reload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_op_q == OP_RELOAD |=> out_valid_q && out_char_q == 8'h00)
    else $error("reload result not zero");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_char_q) && $stable(offs_q))
    else $error("stage one lost a request");

endmodule
